// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

// The condition must never hold.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

// ===== hdl/esm_pkg.sv =====
// ----------------------------------------------------------------------------
// Encoder speed meter package
// Widths, codes and reset values shared by the speed meter files.
// ----------------------------------------------------------------------------
package esm_pkg;

  localparam int WIN_DEPTH = 8;
  localparam int WIN_LOG2  = $clog2(WIN_DEPTH);
  localparam int IDX_W     = (WIN_LOG2 > 0) ? WIN_LOG2 : 1;
  localparam int SUM_W     = 17 + WIN_LOG2;

  localparam int DATA_W    = 16;
  localparam int CNT_W     = 15;
  localparam int CPR_W     = 16;
  localparam int RATE_W    = 14;
  localparam int CMD_W     = 2;
  localparam int DIR_W     = 2;
  localparam int OVP_W     = 32;
  localparam int FULL_W    = 34;
  localparam int RPROD_W   = DATA_W + RATE_W + 1;
  localparam int DIV_W     = 35;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int RPM_SECONDS = 60;

  localparam logic [CPR_W-1:0]  CPR_RESET  = CPR_W'(2048);
  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(100);

  localparam logic [CFG_IDX_W-1:0] CFG_CPR  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RATE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_INV  = CFG_IDX_W'(2);

  typedef enum logic [CMD_W-1:0] {
    CMD_OVERFLOW = 2'd0,
    CMD_SAMPLE   = 2'd1,
    CMD_CLEAR    = 2'd2
  } cmd_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } dir_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OVMUL,
    ST_UPDATE,
    ST_MEAN,
    ST_RATE,
    ST_SCALE,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_t;

endpackage

// ===== hdl/esm_in_if.sv =====
// ----------------------------------------------------------------------------
// Speed meter command channel
// Carries one command item with its counter reading and count direction.
// ----------------------------------------------------------------------------
interface esm_in_if;
  logic                      valid;
  logic                      ready;
  logic [esm_pkg::CMD_W-1:0] cmd;
  logic [esm_pkg::CNT_W-1:0] counter_value;
  logic                      counting_down;

  modport source (output valid, cmd, counter_value, counting_down, input ready);
  modport sink (input valid, cmd, counter_value, counting_down, output ready);
endinterface

// ===== hdl/esm_out_if.sv =====
// ----------------------------------------------------------------------------
// Speed meter result channel
// Carries one result item: count delta, direction code and average speed.
// ----------------------------------------------------------------------------
interface esm_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [esm_pkg::DATA_W-1:0] count_delta;
  logic        [esm_pkg::DIR_W-1:0]  direction_code;
  logic signed [esm_pkg::DATA_W-1:0] average_rpm;

  modport source (output valid, count_delta, direction_code, average_rpm, input ready);
  modport sink (input valid, count_delta, direction_code, average_rpm, output ready);
endinterface

// ===== hdl/esm_div.sv =====
// ----------------------------------------------------------------------------
// Speed meter divider
// Restoring unsigned divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module esm_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [esm_pkg::DIV_W-1:0]        dividend,
  input  logic [esm_pkg::CPR_W-1:0]        divisor,
  output logic                             done,
  output logic [esm_pkg::DIV_W-1:0]        quotient
);

  logic                              busy;
  logic [esm_pkg::DIV_CNT_W-1:0]     cnt;
  logic [esm_pkg::CPR_W-1:0]         rem;
  logic [esm_pkg::DIV_W-1:0]         quo;
  logic [esm_pkg::CPR_W-1:0]         dvs;
  logic [esm_pkg::CPR_W:0]           trial;
  logic                              fits;

  assign trial    = {rem, quo[esm_pkg::DIV_W-1]};
  assign fits     = (trial >= {1'b0, dvs});
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= esm_pkg::DIV_CNT_W'(esm_pkg::DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == esm_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= esm_pkg::CPR_W'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[esm_pkg::CPR_W-1:0];
      end
      quo <= {quo[esm_pkg::DIV_W-2:0], fits};
    end
  end

  `ASSERT_NEVER(a_div_restart, start && busy, "divider started while busy")
  `ASSERT_NEXT(a_div_finish, busy && (cnt == esm_pkg::DIV_CNT_W'(1)), done && !busy, "divider missed its last step")

endmodule

// ===== hdl/encoder_speed_meter_core.sv =====
// ----------------------------------------------------------------------------
// Encoder speed meter core
// Counts encoder overflows, forms the count delta per sample, keeps a moving
// window of deltas and reports the window mean in revolutions per minute.
// ----------------------------------------------------------------------------
// Every command item yields exactly one result item. A new command item is
// taken only once the previous item has placed its result in the output
// register, which waits until the result before it has been taken. The rpm
// conversion divides by counts_per_rev in a restoring divider at one quotient
// bit per cycle. A finished result waits in the output register while the next
// item is accepted. Configuration writes take effect at once and must only be
// issued while the block is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module encoder_speed_meter_core (
  input  logic                              clk,
  input  logic                              rst,
  esm_in_if.sink                            req,
  esm_out_if.source                         rsp,
  input  logic                              cfg_we,
  input  logic [esm_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [esm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  esm_pkg::state_t state, state_next;

  logic [esm_pkg::CPR_W-1:0]  counts_per_rev;
  logic [esm_pkg::RATE_W-1:0] sample_rate_hz;
  logic                       invert_direction;

  logic [esm_pkg::CMD_W-1:0]  cmd_q;
  logic [esm_pkg::CNT_W-1:0]  cur_q;
  logic                       down_q;

  logic [esm_pkg::DATA_W-1:0]        ovf_cnt;
  logic [esm_pkg::CNT_W-1:0]         prev_cnt;
  logic                              first_pend;
  logic signed [esm_pkg::DATA_W-1:0] win [esm_pkg::WIN_DEPTH];
  logic [esm_pkg::WIN_DEPTH-1:0]     win_vld;
  logic [esm_pkg::IDX_W-1:0]         win_idx;
  logic signed [esm_pkg::SUM_W-1:0]  win_sum;

  logic [esm_pkg::OVP_W-1:0]          ov_prod;
  logic signed [esm_pkg::DATA_W-1:0]  delta_q;
  esm_pkg::dir_t                      dir_q;
  logic signed [esm_pkg::DATA_W-1:0]  mean_q;
  logic signed [esm_pkg::RPROD_W-1:0] rate_prod;
  logic                               rpm_neg;
  logic signed [esm_pkg::DATA_W-1:0]  rpm_q;

  logic signed [esm_pkg::DATA_W-1:0]  d_diff;
  logic signed [esm_pkg::FULL_W-1:0]  full;
  logic signed [esm_pkg::FULL_W-1:0]  full_s;
  logic                               neg;
  logic signed [esm_pkg::DATA_W-1:0]  delta_new;
  esm_pkg::dir_t                      dir_new;
  logic signed [esm_pkg::DATA_W-1:0]  old_val;
  logic signed [esm_pkg::SUM_W-1:0]   sum_new;
  logic signed [esm_pkg::SUM_W-1:0]   sum_adj;
  logic signed [esm_pkg::SUM_W-1:0]   mean_full;
  logic [esm_pkg::RPROD_W-1:0]        rate_mag;
  logic [esm_pkg::DIV_W-1:0]          scaled;
  logic [esm_pkg::DATA_W-1:0]         quo_low;
  logic [esm_pkg::IDX_W-1:0]          idx_inc;

  logic                               div_start;
  logic                               div_done;
  logic [esm_pkg::DIV_W-1:0]          div_quo;
  logic                               out_free;

  // Delta of the current sample against the previous reading.
  assign d_diff  = $signed({1'b0, cur_q}) - $signed({1'b0, prev_cnt});
  assign full    = down_q ? ($signed({2'b00, ov_prod}) - esm_pkg::FULL_W'(d_diff))
                          : ($signed({2'b00, ov_prod}) + esm_pkg::FULL_W'(d_diff));
  assign neg     = down_q ^ invert_direction;
  assign full_s  = neg ? -full : full;

  always_comb begin
    if (first_pend) begin
      delta_new = '0;
      dir_new   = esm_pkg::DIR_STOP;
    end else begin
      delta_new = full_s[esm_pkg::DATA_W-1:0];
      if (full == '0) begin
        dir_new = esm_pkg::DIR_STOP;
      end else if (neg) begin
        dir_new = esm_pkg::DIR_REV;
      end else begin
        dir_new = esm_pkg::DIR_FWD;
      end
    end
  end

  assign old_val = win_vld[win_idx] ? win[win_idx] : '0;
  assign sum_new = win_sum - esm_pkg::SUM_W'(old_val) + esm_pkg::SUM_W'(delta_new);
  assign idx_inc = (win_idx == esm_pkg::IDX_W'(esm_pkg::WIN_DEPTH - 1)) ? '0
                                                                     : win_idx + 1'b1;

  // Mean rounds toward zero.
  assign sum_adj   = win_sum[esm_pkg::SUM_W-1]
                   ? win_sum + esm_pkg::SUM_W'(esm_pkg::WIN_DEPTH - 1) : win_sum;
  assign mean_full = sum_adj >>> esm_pkg::WIN_LOG2;

  assign rate_mag = rate_prod[esm_pkg::RPROD_W-1] ? esm_pkg::RPROD_W'(-rate_prod)
                                                  : esm_pkg::RPROD_W'(rate_prod);
  assign scaled   = esm_pkg::DIV_W'(rate_mag) * esm_pkg::DIV_W'(esm_pkg::RPM_SECONDS);
  assign quo_low  = div_quo[esm_pkg::DATA_W-1:0];
  assign out_free = !rsp.valid || rsp.ready;

  esm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (scaled),
    .divisor  (counts_per_rev),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      esm_pkg::ST_IDLE:   if (req.valid) state_next = esm_pkg::ST_OVMUL;
      esm_pkg::ST_OVMUL:  state_next = esm_pkg::ST_UPDATE;
      esm_pkg::ST_UPDATE: state_next = esm_pkg::ST_MEAN;
      esm_pkg::ST_MEAN:   state_next = esm_pkg::ST_RATE;
      esm_pkg::ST_RATE:   state_next = esm_pkg::ST_SCALE;
      esm_pkg::ST_SCALE:  state_next = esm_pkg::ST_DIV;
      esm_pkg::ST_DIV:    if (div_done) state_next = esm_pkg::ST_FIN;
      esm_pkg::ST_FIN:    state_next = esm_pkg::ST_OUT;
      esm_pkg::ST_OUT:    if (out_free) state_next = esm_pkg::ST_IDLE;
      default:            state_next = esm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = (state == esm_pkg::ST_IDLE);
    div_start = (state == esm_pkg::ST_SCALE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= esm_pkg::ST_IDLE;
      counts_per_rev   <= esm_pkg::CPR_RESET;
      sample_rate_hz   <= esm_pkg::RATE_RESET;
      invert_direction <= 1'b0;
      ovf_cnt          <= '0;
      prev_cnt         <= '0;
      first_pend       <= 1'b1;
      win_vld          <= '0;
      win_idx          <= '0;
      win_sum          <= '0;
      rsp.valid        <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_idx)
          esm_pkg::CFG_CPR:  counts_per_rev   <= cfg_wdata[esm_pkg::CPR_W-1:0];
          esm_pkg::CFG_RATE: sample_rate_hz   <= cfg_wdata[esm_pkg::RATE_W-1:0];
          esm_pkg::CFG_INV:  invert_direction <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (state == esm_pkg::ST_UPDATE) begin
        case (cmd_q)
          esm_pkg::CMD_OVERFLOW: begin
            if (ovf_cnt != '1) ovf_cnt <= ovf_cnt + 1'b1;
          end
          esm_pkg::CMD_SAMPLE: begin
            first_pend       <= 1'b0;
            ovf_cnt          <= '0;
            prev_cnt         <= cur_q;
            win_vld[win_idx] <= 1'b1;
            win_sum          <= sum_new;
            win_idx          <= idx_inc;
          end
          esm_pkg::CMD_CLEAR: begin
            win_vld    <= '0;
            win_sum    <= '0;
            first_pend <= 1'b1;
          end
          default: ;
        endcase
      end
      if (state == esm_pkg::ST_OUT && out_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      cmd_q  <= req.cmd;
      cur_q  <= req.counter_value;
      down_q <= req.counting_down;
    end
    if (state == esm_pkg::ST_OVMUL) begin
      ov_prod <= ovf_cnt * counts_per_rev;
    end
    if (state == esm_pkg::ST_UPDATE) begin
      if (cmd_q == esm_pkg::CMD_SAMPLE) begin
        win[win_idx] <= delta_new;
        delta_q      <= delta_new;
        dir_q        <= dir_new;
      end else begin
        delta_q <= '0;
        dir_q   <= esm_pkg::DIR_STOP;
      end
    end
    if (state == esm_pkg::ST_MEAN) begin
      mean_q <= mean_full[esm_pkg::DATA_W-1:0];
    end
    if (state == esm_pkg::ST_RATE) begin
      rate_prod <= mean_q * $signed({1'b0, sample_rate_hz});
    end
    if (state == esm_pkg::ST_SCALE) begin
      rpm_neg <= rate_prod[esm_pkg::RPROD_W-1];
    end
    if (state == esm_pkg::ST_FIN) begin
      if (counts_per_rev == '0) begin
        rpm_q <= '0;
      end else if (rpm_neg) begin
        rpm_q <= -$signed(quo_low);
      end else begin
        rpm_q <= $signed(quo_low);
      end
    end
    if (state == esm_pkg::ST_OUT && out_free) begin
      rsp.count_delta    <= delta_q;
      rsp.direction_code <= dir_q;
      rsp.average_rpm    <= rpm_q;
    end
  end

  `ASSERT_NEXT(a_first_zero, (state == esm_pkg::ST_UPDATE) && (cmd_q == esm_pkg::CMD_SAMPLE) && first_pend, (delta_q == '0) && (dir_q == esm_pkg::DIR_STOP), "first sample gave a nonzero delta")
  `ASSERT_NEXT(a_sample_ovf, (state == esm_pkg::ST_UPDATE) && (cmd_q == esm_pkg::CMD_SAMPLE), (ovf_cnt == '0) && !first_pend, "sample did not reset the overflow count")
  `ASSERT_NEXT(a_clear_win, (state == esm_pkg::ST_UPDATE) && (cmd_q == esm_pkg::CMD_CLEAR), (win_sum == '0) && (win_vld == '0) && first_pend, "clear left window state behind")

endmodule

// ===== dv/esm_speed_checker.sv =====
// ----------------------------------------------------------------------------
// Encoder speed meter checker
// Watches the command and result channels and the register port, keeps its
// own copy of the overflow count, sample history and delta window, works out
// the count delta, direction and average rpm for every accepted command item
// and compares each result item with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module esm_speed_checker (
  input  logic                                clk,
  input  logic                                rst,
  esm_in_if                                   req,
  esm_out_if                                  rsp,
  input  logic                                cfg_we,
  input  logic [esm_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [esm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output int                                  pending,
  output int                                  fails
);

  typedef struct packed {
    logic signed [esm_pkg::DATA_W-1:0] delta;
    esm_pkg::dir_t                     dir;
    logic signed [esm_pkg::DATA_W-1:0] rpm;
  } speed_result_t;

  logic [esm_pkg::CPR_W-1:0]         cpr;
  logic [esm_pkg::RATE_W-1:0]        rate;
  logic                              inv;
  logic [15:0]                       ovf_cnt;
  logic [esm_pkg::CNT_W-1:0]         prev_cnt;
  logic                              first_pending;
  logic signed [esm_pkg::DATA_W-1:0] win [esm_pkg::WIN_DEPTH];
  logic [esm_pkg::IDX_W-1:0]         wr_idx;
  int                                win_sum;
  speed_result_t                     speed_q [$];
  speed_result_t                     oldest;

  function automatic speed_result_t predict_speed(logic [esm_pkg::CMD_W-1:0] c,
                                                  logic [esm_pkg::CNT_W-1:0] cv,
                                                  logic down);
    longint        d;
    longint        ov;
    longint        full;
    longint        mean;
    longint        rpm;
    logic          neg;
    speed_result_t r;
    r.delta = '0;
    r.dir   = esm_pkg::DIR_STOP;
    case (c)
      esm_pkg::CMD_OVERFLOW: begin
        if (ovf_cnt != 16'hFFFF) ovf_cnt = ovf_cnt + 16'd1;
      end
      esm_pkg::CMD_SAMPLE: begin
        if (!first_pending) begin
          d    = longint'(cv) - longint'(prev_cnt);
          ov   = longint'(ovf_cnt) * longint'(cpr);
          full = down ? ov - d : d + ov;
          neg  = down ^ inv;
          if (neg) full = -full;
          r.dir   = (full == 0) ? esm_pkg::DIR_STOP
                                : (neg ? esm_pkg::DIR_REV : esm_pkg::DIR_FWD);
          r.delta = full[esm_pkg::DATA_W-1:0];
        end
        first_pending = 1'b0;
        ovf_cnt       = '0;
        prev_cnt      = cv;
        win_sum       = win_sum - int'($signed(win[wr_idx])) + int'($signed(r.delta));
        win[wr_idx]   = r.delta;
        wr_idx        = wr_idx + 1'b1;
      end
      esm_pkg::CMD_CLEAR: begin
        foreach (win[i]) win[i] = '0;
        win_sum       = 0;
        first_pending = 1'b1;
      end
      default: begin
      end
    endcase
    if (cpr == '0) begin
      r.rpm = '0;
    end else begin
      mean  = longint'(win_sum) / esm_pkg::WIN_DEPTH;
      rpm   = mean * longint'(rate) * esm_pkg::RPM_SECONDS / longint'(cpr);
      r.rpm = rpm[esm_pkg::DATA_W-1:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, int want, int got);
    $display("%0t speed meter mismatch on %s: expected %0d, got %0d",
             $realtime, field, want, got);
    fails = fails + 1;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cpr           = esm_pkg::CPR_RESET;
      rate          = esm_pkg::RATE_RESET;
      inv           = 1'b0;
      ovf_cnt       = '0;
      prev_cnt      = '0;
      first_pending = 1'b1;
      foreach (win[i]) win[i] = '0;
      wr_idx        = '0;
      win_sum       = 0;
      speed_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          esm_pkg::CFG_CPR:  cpr  = cfg_wdata[esm_pkg::CPR_W-1:0];
          esm_pkg::CFG_RATE: rate = cfg_wdata[esm_pkg::RATE_W-1:0];
          esm_pkg::CFG_INV:  inv  = cfg_wdata[0];
          default: begin
          end
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        if (speed_q.size() == 0) begin
          report_mismatch("result item with no command pending", 0, int'(rsp.count_delta));
        end else begin
          oldest = speed_q.pop_front();
          if (rsp.count_delta !== oldest.delta)
            report_mismatch("count_delta", int'(oldest.delta), int'(rsp.count_delta));
          if (rsp.direction_code !== oldest.dir)
            report_mismatch("direction_code", int'(oldest.dir), int'(rsp.direction_code));
          if (rsp.average_rpm !== oldest.rpm)
            report_mismatch("average_rpm", int'(oldest.rpm), int'(rsp.average_rpm));
        end
      end
      if (req.valid && req.ready)
        speed_q.push_back(predict_speed(req.cmd, req.counter_value, req.counting_down));
    end
    pending = speed_q.size();
  end

endmodule

// ===== dv/encoder_speed_meter_core_tb.sv =====
// ----------------------------------------------------------------------------
// Encoder speed meter testbench
// Drives directed and random command items through the speed meter under
// several register settings and three idling patterns, holds the result
// channel off for a long stretch once, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module encoder_speed_meter_core_tb;

  localparam logic [esm_pkg::CMD_W-1:0]     CMD_UNUSED      = esm_pkg::CMD_W'(3);
  localparam logic [esm_pkg::CFG_IDX_W-1:0] CFG_SPARE       = esm_pkg::CFG_IDX_W'(3);
  localparam int                            STALL_LIMIT     = 4000;
  localparam int                            SETTLE_CYCLES   = 60;
  localparam int                            HOLD_CYCLES     = 400;
  localparam int                            PHASES_PER_MODE = 5;
  localparam int                            ITEMS_PER_PHASE = 122;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [esm_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [esm_pkg::CFG_DATA_W-1:0] cfg_wdata;
  int                             chk_pending;
  int                             chk_fails;
  int                             tx_idle_pct;
  int                             rx_idle_pct;
  int                             hold_reqs;
  int                             hold_seen;
  int                             hold_left;
  int                             stall_cycles;

  esm_in_if  req_ch ();
  esm_out_if rsp_ch ();

  encoder_speed_meter_core dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  esm_speed_checker speed_chk (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .pending   (chk_pending),
    .fails     (chk_fails)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The result side runs on its own; a new hold request keeps ready low for a
  // long stretch so that the block fills up and stops taking command items.
  always @(negedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_item(logic [esm_pkg::CMD_W-1:0] c, logic [esm_pkg::CNT_W-1:0] cv,
                           logic down);
    while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.cmd           <= c;
    req_ch.counter_value <= cv;
    req_ch.counting_down <= down;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [esm_pkg::CFG_IDX_W-1:0] idx,
                           logic [esm_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic settle();
    req_ch.valid <= 1'b0;
    while (chk_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [esm_pkg::CMD_W-1:0]      c;
    logic [esm_pkg::CNT_W-1:0]      cv;
    logic [esm_pkg::CNT_W-1:0]      last_cv;
    logic [esm_pkg::CNT_W-1:0]      step;
    logic                           dir_down;
    logic [esm_pkg::CFG_DATA_W-1:0] cpr_pick;
    logic [esm_pkg::CFG_DATA_W-1:0] rate_pick;
    int                             pick;
    clk                  = 1'b0;
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_idx              = '0;
    cfg_wdata            = '0;
    req_ch.valid         = 1'b0;
    req_ch.cmd           = esm_pkg::CMD_OVERFLOW;
    req_ch.counter_value = '0;
    req_ch.counting_down = 1'b0;
    rsp_ch.ready         = 1'b0;
    tx_idle_pct          = 38;
    rx_idle_pct          = 84;
    last_cv              = '0;
    dir_down             = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_item(esm_pkg::CMD_SAMPLE, 15'd100, 1'b0);
    send_item(esm_pkg::CMD_SAMPLE, 15'd300, 1'b0);
    send_item(esm_pkg::CMD_SAMPLE, 15'd300, 1'b0);
    send_item(esm_pkg::CMD_SAMPLE, 15'd100, 1'b1);
    send_item(esm_pkg::CMD_OVERFLOW, 15'd0, 1'b0);
    send_item(esm_pkg::CMD_OVERFLOW, 15'd0, 1'b0);
    send_item(esm_pkg::CMD_SAMPLE, 15'd0, 1'b0);
    send_item(esm_pkg::CMD_SAMPLE, 15'h7FFF, 1'b0);
    send_item(esm_pkg::CMD_SAMPLE, 15'd0, 1'b1);
    send_item(esm_pkg::CMD_CLEAR, 15'h7FFF, 1'b1);
    send_item(esm_pkg::CMD_OVERFLOW, 15'd0, 1'b0);
    send_item(esm_pkg::CMD_SAMPLE, 15'd5, 1'b0);
    send_item(CMD_UNUSED, 15'h7FFF, 1'b1);
    send_item(esm_pkg::CMD_SAMPLE, 15'd20, 1'b0);
    settle();
    write_reg(esm_pkg::CFG_INV, 16'd1);
    write_reg(esm_pkg::CFG_CPR, 16'h8000);
    write_reg(esm_pkg::CFG_RATE, 16'd10000);
    write_reg(CFG_SPARE, 16'hFFFF);
    send_item(esm_pkg::CMD_OVERFLOW, 15'd0, 1'b0);
    send_item(esm_pkg::CMD_OVERFLOW, 15'd0, 1'b0);
    send_item(esm_pkg::CMD_OVERFLOW, 15'd0, 1'b0);
    send_item(esm_pkg::CMD_SAMPLE, 15'h7FFF, 1'b0);
    send_item(esm_pkg::CMD_SAMPLE, 15'd0, 1'b1);
    send_item(esm_pkg::CMD_SAMPLE, 15'd16384, 1'b1);
    settle();
    write_reg(esm_pkg::CFG_CPR, 16'd1);
    write_reg(esm_pkg::CFG_RATE, 16'd1);
    write_reg(esm_pkg::CFG_INV, 16'd0);
    send_item(esm_pkg::CMD_OVERFLOW, 15'd0, 1'b0);
    send_item(esm_pkg::CMD_SAMPLE, 15'd1000, 1'b1);
    send_item(esm_pkg::CMD_SAMPLE, 15'd2000, 1'b0);
    settle();
    write_reg(esm_pkg::CFG_CPR, 16'd0);
    send_item(esm_pkg::CMD_SAMPLE, 15'd3000, 1'b0);
    send_item(esm_pkg::CMD_OVERFLOW, 15'd0, 1'b0);
    send_item(esm_pkg::CMD_SAMPLE, 15'd100, 1'b1);

    for (int mode = 0; mode < 3; mode++) begin
      for (int ph = 0; ph < PHASES_PER_MODE; ph++) begin
        settle();
        tx_idle_pct = (mode == 0) ? 38 : (mode == 1) ? 84 : 0;
        rx_idle_pct = (mode == 0) ? 84 : (mode == 1) ? 38 : 0;
        case ($urandom_range(4))
          0:       cpr_pick = 16'd1;
          1:       cpr_pick = 16'h8000;
          2:       cpr_pick = 16'($urandom_range(32768, 1));
          default: cpr_pick = 16'($urandom_range(4096, 1));
        endcase
        case ($urandom_range(3))
          0:       rate_pick = 16'd1;
          1:       rate_pick = 16'd10000;
          default: rate_pick = 16'($urandom_range(10000, 1));
        endcase
        write_reg(esm_pkg::CFG_CPR, cpr_pick);
        write_reg(esm_pkg::CFG_RATE, rate_pick);
        write_reg(esm_pkg::CFG_INV, 16'($urandom_range(1)));
        if (mode == 2 && ph == 1) hold_reqs = hold_reqs + 1;
        for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
          pick = $urandom_range(99);
          if (pick < 68)      c = esm_pkg::CMD_SAMPLE;
          else if (pick < 88) c = esm_pkg::CMD_OVERFLOW;
          else if (pick < 96) c = esm_pkg::CMD_CLEAR;
          else                c = CMD_UNUSED;
          if ($urandom_range(9) == 0) dir_down = ~dir_down;
          step = esm_pkg::CNT_W'($urandom_range(400));
          case ($urandom_range(9))
            0:       cv = esm_pkg::CNT_W'($urandom);
            1:       cv = $urandom_range(1) ? '1 : '0;
            default: cv = dir_down ? last_cv - step : last_cv + step;
          endcase
          if (c == esm_pkg::CMD_SAMPLE) last_cv = cv;
          send_item(c, cv, ($urandom_range(19) == 0) ? ~dir_down : dir_down);
        end
      end
    end
    settle();

    if (chk_fails == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/esm_pkg.sv
hdl/esm_in_if.sv
hdl/esm_out_if.sv
hdl/esm_div.sv
hdl/encoder_speed_meter_core.sv
dv/esm_speed_checker.sv
dv/encoder_speed_meter_core_tb.sv
